@@ design/msom_pkg.sv @@
// Shared types, register map and ordering test for the merge sort block.
package msom_pkg;

  typedef logic [31:0] data_t;
  typedef logic [2:0]  apb_addr_t;
  typedef logic [31:0] apb_data_t;

  localparam logic REG_DESCENDING = 1'b0;

  function automatic logic goes_first(input data_t x, input data_t y, input logic desc);
    logic res;
    if (desc) begin
      res = $signed(x) > $signed(y);
    end else begin
      res = $signed(x) < $signed(y);
    end
    return res;
  endfunction

endpackage

@@ design/merge_sort_with_order_mode_top.sv @@
// Top level of the merge sort block with selectable order.
// Values stream in one transfer per cycle until a transfer marked tlast; a set holds up to
// MAX_ITEMS values and further ones are dropped, which tuser then flags on every result of the
// set. The set is sorted by a bottom-up merge that ping-pongs between two memories through one
// shared comparator, over ceil(log2(n)) passes. Each pass reads then writes every element in
// turn (ST_MRD, ST_MWR), with a setup state (ST_SEG) before each merged run segment. The sorted
// values then leave one at a time, each read, loaded and held until taken (ST_ERD, ST_ELD,
// ST_EWT), the last marked with tlast. The block takes no input while sorting or sending.
module merge_sort_with_order_mode_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  msom_pkg::data_t   s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output msom_pkg::data_t   m_axis_tdata,   // [31:0] value_res
  output logic              m_axis_tlast,
  output logic              m_axis_tuser,   // [0] overflowed
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  msom_pkg::apb_addr_t paddr,
  input  msom_pkg::apb_data_t pwdata,
  output msom_pkg::apb_data_t prdata,
  output logic              pready
);
  import msom_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int CW = AW + 2;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_ITEMS);

  typedef enum logic [2:0] {
    ST_LOAD, ST_SEG, ST_MRD, ST_MWR, ST_ERD, ST_ELD, ST_EWT
  } state_e;

  state_e          state_q;
  logic [NW-1:0]   count_q;
  logic            drop_q;
  logic            desc_q;
  logic            bank_q;
  logic [CW-1:0]   w_q, lo_q, i_q, j_q, mid_q, hi_q, k_q, e_q;
  logic            out_valid_q, out_last_q, out_user_q;
  data_t           out_data_q;

  data_t mem_a [MAX_ITEMS];
  data_t mem_b [MAX_ITEMS];
  data_t rd_a0_q, rd_a1_q, rd_b0_q, rd_b1_q;

  logic            in_xfer, out_xfer, cfg_wr, store_ok;
  logic [NW-1:0]   count_d;
  logic [CW-1:0]   n_ext, seg_mid, seg_hi, k_next, w_next;
  logic [AW-1:0]   ra0, ra1, wa;
  logic            we_a, we_b, take_i;
  data_t           wd, d0, d1, merged;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && (paddr[2] == REG_DESCENDING);
  assign prdata        = (paddr[2] == REG_DESCENDING) ? {31'b0, desc_q} : '0;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = out_valid_q && m_axis_tready;
  assign store_ok = (count_q < MAX_N);
  assign count_d  = store_ok ? count_q + NW'(1) : count_q;

  assign n_ext   = CW'(count_q);
  assign seg_mid = ((lo_q + w_q) < n_ext) ? (lo_q + w_q) : n_ext;
  assign seg_hi  = ((lo_q + (w_q << 1)) < n_ext) ? (lo_q + (w_q << 1)) : n_ext;
  assign k_next  = k_q + CW'(1);
  assign w_next  = w_q << 1;

  assign d0     = bank_q ? rd_b0_q : rd_a0_q;
  assign d1     = bank_q ? rd_b1_q : rd_a1_q;
  assign take_i = (i_q < mid_q) && ((j_q >= hi_q) || goes_first(d0, d1, desc_q));
  assign merged = take_i ? d0 : d1;

  assign ra0 = (state_q == ST_MRD) ? i_q[AW-1:0] : e_q[AW-1:0];
  assign ra1 = j_q[AW-1:0];
  assign wa  = (state_q == ST_LOAD) ? count_q[AW-1:0] : k_q[AW-1:0];
  assign wd  = (state_q == ST_LOAD) ? s_axis_tdata : merged;
  assign we_a = (in_xfer && store_ok) || ((state_q == ST_MWR) && bank_q);
  assign we_b = (state_q == ST_MWR) && !bank_q;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa] <= wd;
    end
    rd_a0_q <= mem_a[ra0];
    rd_a1_q <= mem_a[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wa] <= wd;
    end
    rd_b0_q <= mem_b[ra0];
    rd_b1_q <= mem_b[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      drop_q      <= 1'b0;
      desc_q      <= 1'b0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        desc_q <= pwdata[0];
      end
      case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            count_q <= count_d;
            if (!store_ok) begin
              drop_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              bank_q <= 1'b0;
              w_q    <= CW'(1);
              lo_q   <= '0;
              e_q    <= '0;
              state_q <= (count_d <= NW'(1)) ? ST_ERD : ST_SEG;
            end
          end
        end
        ST_SEG: begin
          i_q     <= lo_q;
          k_q     <= lo_q;
          mid_q   <= seg_mid;
          j_q     <= seg_mid;
          hi_q    <= seg_hi;
          state_q <= ST_MRD;
        end
        ST_MRD: begin
          state_q <= ST_MWR;
        end
        ST_MWR: begin
          if (take_i) begin
            i_q <= i_q + CW'(1);
          end else begin
            j_q <= j_q + CW'(1);
          end
          k_q <= k_next;
          if (k_next == hi_q) begin
            if (hi_q == n_ext) begin
              w_q    <= w_next;
              bank_q <= !bank_q;
              lo_q   <= '0;
              state_q <= (w_next >= n_ext) ? ST_ERD : ST_SEG;
            end else begin
              lo_q    <= hi_q;
              state_q <= ST_SEG;
            end
          end else begin
            state_q <= ST_MRD;
          end
        end
        ST_ERD: begin
          state_q <= ST_ELD;
        end
        ST_ELD: begin
          out_valid_q <= 1'b1;
          out_data_q  <= d0;
          out_last_q  <= (e_q + CW'(1) == n_ext);
          out_user_q  <= drop_q;
          state_q     <= ST_EWT;
        end
        ST_EWT: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              count_q <= '0;
              drop_q  <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              e_q     <= e_q + CW'(1);
              state_q <= ST_ERD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_N)
    else $error("item count beyond capacity");

  a_mid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input reopened before the set was sent");

  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> (count_q == '0) && !drop_q)
    else $error("set state not cleared after final transfer");

endmodule

@@ bench/merge_sort_with_order_mode_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the merge sort block, covering directed sets and random phases.
module merge_sort_with_order_mode_top_tb;
  import msom_pkg::*;

  localparam int MAX_ITEMS     = 64;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_PAUSE    = 8;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    data_t     value;
    logic      last;
    logic      hand_checked;
  } dir_row_t;

  typedef struct packed {
    data_t value;
    logic  last;
    logic  ovf;
  } sorted_t;

  logic      clk_i;
  logic      rst_ni;
  logic      s_axis_tvalid;
  logic      s_axis_tready;
  data_t     s_axis_tdata;
  logic      s_axis_tlast;
  logic      m_axis_tvalid;
  logic      m_axis_tready;
  data_t     m_axis_tdata;
  logic      m_axis_tlast;
  logic      m_axis_tuser;
  logic      psel;
  logic      penable;
  logic      pwrite;
  apb_addr_t paddr;
  apb_data_t pwdata;
  apb_data_t prdata;
  logic      pready;

  data_t   held_values[$];
  logic    drop_seen;
  logic    order_desc;
  sorted_t fresh_sorted[$];
  sorted_t expected_sorted[$];
  int      mismatch_count;
  int      cycle_count;
  int      send_idle;
  int      recv_stall;

  dir_row_t dir_rows [22] = '{
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1'b1},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1},
    '{ROW_ITEM, 32'h0000_0005, 1'b0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b0},
    '{ROW_CFG,  32'h0000_0001, 1'b0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1},
    '{ROW_ITEM, 32'h0000_0005, 1'b0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b0},
    '{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h0000_0001, 1'b1, 1'b0},
    '{ROW_CFG,  32'hFFFF_FFFE, 1'b0, 1'b0},
    '{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b0}
  };

  merge_sort_with_order_mode_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2, 3: v = data_t'($urandom_range(0, 6)) - 32'd3;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void take_value(input data_t v, input logic lst);
    data_t tmp;
    logic  ahead;
    int    n;
    fresh_sorted.delete();
    if (held_values.size() < MAX_ITEMS) begin
      held_values.push_back(v);
    end else begin
      drop_seen = 1'b1;
    end
    if (lst) begin
      n = held_values.size();
      for (int i = 1; i < n; i++) begin
        for (int j = i; j > 0; j--) begin
          ahead = order_desc ? ($signed(held_values[j]) > $signed(held_values[j-1]))
                             : ($signed(held_values[j]) < $signed(held_values[j-1]));
          if (!ahead) break;
          tmp              = held_values[j];
          held_values[j]   = held_values[j-1];
          held_values[j-1] = tmp;
        end
      end
      for (int k = 0; k < n; k++) begin
        fresh_sorted.push_back(sorted_t'{held_values[k], k == n - 1, drop_seen});
      end
      held_values.delete();
      drop_seen = 1'b0;
    end
  endfunction

  task automatic send_value(input data_t v, input logic lst, input logic hand_checked);
    @(negedge clk_i);
    while ($urandom_range(1, 100) <= send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    take_value(v, lst);
    if (hand_checked) begin
      expected_sorted.push_back(sorted_t'{v, 1'b1, 1'b0});
    end else begin
      foreach (fresh_sorted[k]) expected_sorted.push_back(fresh_sorted[k]);
    end
  endtask

  task automatic send_set(input int len);
    for (int k = 0; k < len; k++) begin
      send_value(pick_value(), k == len - 1, 1'b0);
    end
  endtask

  task automatic wait_drained(input int pause);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_sorted.size() != 0) @(posedge clk_i);
    repeat (pause) @(posedge clk_i);
  endtask

  task automatic write_desc(input logic desc);
    wait_drained(IDLE_PAUSE);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= apb_addr_t'({REG_DESCENDING, 2'b00});
    pwdata  <= {31'($urandom), desc};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    order_desc = desc;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input sorted_t want, input sorted_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s): expected value %h last %b ovf %b, got value %h last %b ovf %b",
               what, want.value, want.last, want.ovf, got.value, got.last, got.ovf);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(1, 100) > recv_stall);
  end

  always @(posedge clk_i) begin
    sorted_t got;
    sorted_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = sorted_t'{m_axis_tdata, m_axis_tlast, m_axis_tuser};
      if (expected_sorted.size() == 0) begin
        note_mismatch("unexpected transfer", '0, got);
      end else begin
        want = expected_sorted.pop_front();
        if (got != want) note_mismatch("wrong field", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    drop_seen      = 1'b0;
    order_desc     = 1'b0;
    send_idle      = 0;
    recv_stall     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_desc(dir_rows[r].value[0]);
      end else begin
        send_value(dir_rows[r].value, dir_rows[r].last, dir_rows[r].hand_checked);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      write_desc(ph == 3 ? 1'($urandom_range(0, 1)) : ph[0]);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 54; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 54; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      for (int items = 0; items < 6; ) begin
        automatic int len = $urandom_range(1, 6);
        send_set(len);
        items += len;
      end
      if (ph == 3) send_set(MAX_ITEMS + 2);
    end

    wait_drained(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
